// ===== rtl/pbsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsu_pkg
// Shared types and constants for the PCM byte stream unpacker.
// ----------------------------------------------------------------------------
package pbsu_pkg;

   localparam int BYTE_W       = 8;
   localparam int SAMPLE_W     = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 63;
   localparam int LENGTH_W     = 63;
   localparam int SBYTES_W     = 3;
   localparam int CHANS_W      = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_BYTES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_KNOWN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BODY_LENGTH   = 3'd4;

   typedef struct packed {
      logic                       frame_valid;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       body_end;
      logic                       length_error;
      logic                       partial_frame_error;
   } rsp_type;

endpackage

// ===== rtl/pbsu_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsu_out_buf
// Two-entry output stage: result register plus skid register, so the input
// side stall is a registered signal.
// ----------------------------------------------------------------------------
module pbsu_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  pbsu_pkg::rsp_type push_data,
   output logic             push_stall,
   output logic             out_valid,
   output pbsu_pkg::rsp_type out_data,
   input  logic             out_stall
);

   logic              main_valid_ff;
   logic              skid_valid_ff;
   pbsu_pkg::rsp_type main_data_ff;
   pbsu_pkg::rsp_type skid_data_ff;
   logic              main_free;

   assign main_free  = !main_valid_ff || !out_stall;
   assign push_stall = skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= push_valid;
         end else begin
            main_valid_ff <= push_valid;
         end
      end else if (push_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         if (skid_valid_ff) begin
            main_data_ff <= skid_data_ff;
            skid_data_ff <= push_data;
         end else begin
            main_data_ff <= push_data;
         end
      end else if (push_valid) begin
         skid_data_ff <= push_data;
      end
   end

endmodule

// ===== rtl/pcm_byte_stream_unpacker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_byte_stream_unpacker_core
// Gathers PCM body bytes into frames and emits left-justified samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one body byte per word (req_valid / req_stall).
//   rsp_*  : one result word per accepted byte (rsp_valid / rsp_stall),
//            carrying frame_valid, both samples and the end-of-body flags.
//   csr_*  : register writes (index, data); csr_ready is always high.
//            Write only while no byte is in flight.
// Each byte is unpacked against the held frame bytes and registered on the
// accepting edge, in the skid register if the result register is stalled.
// Throughput is one byte per cycle while req_stall stays low.
// A skid register behind the result register absorbs one word when the
// receiver stalls; req_stall rises only once that skid word is occupied.
// Reset clears the held byte count, the remaining-byte counter and the
// registers to their defaults (16-bit stereo, little endian, length unknown).
// ----------------------------------------------------------------------------
module pcm_byte_stream_unpacker_core #(
   parameter int MAX_SAMPLE_BYTES = 4,
   parameter int MAX_CHANNELS     = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pbsu_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_frame_valid,
   output logic signed [pbsu_pkg::SAMPLE_W-1:0]  rsp_left_sample,
   output logic signed [pbsu_pkg::SAMPLE_W-1:0]  rsp_right_sample,
   output logic                                  rsp_body_end,
   output logic                                  rsp_length_error,
   output logic                                  rsp_partial_frame_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pbsu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pbsu_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int USED_CHANNELS = (MAX_CHANNELS > 2) ? 2 : MAX_CHANNELS;
   localparam int HOLD_DEPTH    = MAX_SAMPLE_BYTES * USED_CHANNELS;
   localparam int HCNT_W        = $clog2(HOLD_DEPTH + 1);

   logic [pbsu_pkg::SBYTES_W-1:0] sample_bytes_ff;
   logic [pbsu_pkg::CHANS_W-1:0]  channel_count_ff;
   logic                          big_endian_ff;
   logic                          length_known_ff;
   logic [pbsu_pkg::LENGTH_W-1:0] remaining_ff;
   logic [pbsu_pkg::LENGTH_W-1:0] remaining_in;
   logic [HCNT_W-1:0]             held_cnt_ff;
   logic [HCNT_W-1:0]             held_cnt_in;
   logic [HCNT_W-1:0]             held_cnt_inc;
   logic [pbsu_pkg::BYTE_W-1:0]   held_ff [HOLD_DEPTH];
   logic [pbsu_pkg::BYTE_W-1:0]   cur_bytes [HOLD_DEPTH];

   logic [pbsu_pkg::SBYTES_W-1:0] width_eff;
   logic [pbsu_pkg::CHANS_W-1:0]  chans_eff;
   logic [HCNT_W-1:0]             frame_size;
   logic                          accept;
   logic                          csr_write;
   logic                          len_err;
   logic                          out_buf_stall;
   pbsu_pkg::rsp_type             rsp_in;
   pbsu_pkg::rsp_type             rsp_out;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = out_buf_stall;

   // effective format
   always_comb begin
      if (sample_bytes_ff < 3'd2) begin
         width_eff = 3'd2;
      end else if (32'(sample_bytes_ff) > MAX_SAMPLE_BYTES) begin
         width_eff = pbsu_pkg::SBYTES_W'(MAX_SAMPLE_BYTES);
      end else begin
         width_eff = sample_bytes_ff;
      end
      if (channel_count_ff == 2'd0) begin
         chans_eff = 2'd1;
      end else if (32'(channel_count_ff) > USED_CHANNELS) begin
         chans_eff = pbsu_pkg::CHANS_W'(USED_CHANNELS);
      end else begin
         chans_eff = channel_count_ff;
      end
      if (chans_eff == 2'd2) begin
         frame_size = HCNT_W'({width_eff, 1'b0});
      end else begin
         frame_size = HCNT_W'(width_eff);
      end
   end

   // frame view with the incoming byte in place
   always_comb begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (held_cnt_ff == HCNT_W'(i)) begin
            cur_bytes[i] = req_data_byte;
         end else begin
            cur_bytes[i] = held_ff[i];
         end
      end
   end

   always_comb begin
      int idx;
      int pos;
      logic [pbsu_pkg::BYTE_W-1:0] sel;
      logic [pbsu_pkg::SAMPLE_W-1:0] samp [2];

      len_err      = length_known_ff && (remaining_ff == '0);
      remaining_in = remaining_ff;
      held_cnt_in  = held_cnt_ff;
      held_cnt_inc = held_cnt_ff + HCNT_W'(1);
      rsp_in       = '0;

      for (int ch = 0; ch < 2; ch++) begin
         samp[ch] = '0;
         for (int b = 0; b < MAX_SAMPLE_BYTES; b++) begin
            pos = big_endian_ff ? b : (32'(width_eff) - 1 - b);
            idx = ch * 32'(width_eff) + pos;
            sel = '0;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               if (idx == i) begin
                  sel = cur_bytes[i];
               end
            end
            if (b < 32'(width_eff)) begin
               samp[ch][pbsu_pkg::SAMPLE_W-1-pbsu_pkg::BYTE_W*b -: pbsu_pkg::BYTE_W] = sel;
            end
         end
      end

      if (!len_err) begin
         if (length_known_ff) begin
            remaining_in = remaining_ff - pbsu_pkg::LENGTH_W'(1);
         end
         if (held_cnt_inc >= frame_size) begin
            held_cnt_in        = '0;
            rsp_in.frame_valid = 1'b1;
            rsp_in.left_sample = samp[0];
            if (chans_eff == 2'd2) begin
               rsp_in.right_sample = samp[1];
            end
         end else begin
            held_cnt_in = held_cnt_inc;
         end
      end

      rsp_in.length_error        = len_err;
      rsp_in.body_end            = length_known_ff && (remaining_in == '0);
      rsp_in.partial_frame_error = rsp_in.body_end && (held_cnt_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bytes_ff  <= 3'd2;
         channel_count_ff <= 2'd2;
         big_endian_ff    <= 1'b0;
         length_known_ff  <= 1'b0;
         remaining_ff     <= '0;
         held_cnt_ff      <= '0;
      end else begin
         if (accept) begin
            remaining_ff <= remaining_in;
            held_cnt_ff  <= held_cnt_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               pbsu_pkg::CSR_SAMPLE_BYTES: begin
                  sample_bytes_ff <= csr_data[pbsu_pkg::SBYTES_W-1:0];
               end
               pbsu_pkg::CSR_CHANNEL_COUNT: begin
                  channel_count_ff <= csr_data[pbsu_pkg::CHANS_W-1:0];
               end
               pbsu_pkg::CSR_BIG_ENDIAN: begin
                  big_endian_ff <= csr_data[0];
               end
               pbsu_pkg::CSR_LENGTH_KNOWN: begin
                  length_known_ff <= csr_data[0];
               end
               pbsu_pkg::CSR_BODY_LENGTH: begin
                  remaining_ff <= csr_data[pbsu_pkg::LENGTH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (accept && !len_err && held_cnt_ff == HCNT_W'(i)) begin
            held_ff[i] <= req_data_byte;
         end
      end
   end

   pbsu_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_data  (rsp_in),
      .push_stall (out_buf_stall),
      .out_valid  (rsp_valid),
      .out_data   (rsp_out),
      .out_stall  (rsp_stall)
   );

   assign rsp_frame_valid         = rsp_out.frame_valid;
   assign rsp_left_sample         = rsp_out.left_sample;
   assign rsp_right_sample        = rsp_out.right_sample;
   assign rsp_body_end            = rsp_out.body_end;
   assign rsp_length_error        = rsp_out.length_error;
   assign rsp_partial_frame_error = rsp_out.partial_frame_error;

`ifndef SYNTHESIS
   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff < HCNT_W'(HOLD_DEPTH))
      else $error("held byte count out of range");

   a_dropped_byte_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      accept && len_err |=> $stable(held_cnt_ff))
      else $error("dropped byte changed the held frame");

   a_err_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> !rsp_frame_valid && rsp_body_end)
      else $error("length error word carries a frame or lacks the body end flag");

   a_partial_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_partial_frame_error |-> rsp_body_end && !rsp_frame_valid)
      else $error("partial frame flagged without end of body");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCM byte stream unpacker core. Feeds body
// bytes through the req channel under random sender gaps and receiver stalls.
// A local unpacking predictor tracks the frame format, held bytes and the
// remaining-length counter. Every rsp word is checked against the oldest
// prediction. Register settings change between drained phases, including
// out-of-range formats, mid-frame format changes and known-length bodies
// that end early, end on a partial frame or overrun.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT   = 800000;
   localparam int RANDOM_BYTES  = 1800;
   localparam int HOLD_DEPTH    = 8;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [pbsu_pkg::BYTE_W-1:0]          req_data_byte = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_frame_valid;
   logic signed [pbsu_pkg::SAMPLE_W-1:0] rsp_left_sample;
   logic signed [pbsu_pkg::SAMPLE_W-1:0] rsp_right_sample;
   logic                                 rsp_body_end;
   logic                                 rsp_length_error;
   logic                                 rsp_partial_frame_error;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [pbsu_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [pbsu_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   pcm_byte_stream_unpacker_core i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_data_byte           (req_data_byte),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_frame_valid         (rsp_frame_valid),
      .rsp_left_sample         (rsp_left_sample),
      .rsp_right_sample        (rsp_right_sample),
      .rsp_body_end            (rsp_body_end),
      .rsp_length_error        (rsp_length_error),
      .rsp_partial_frame_error (rsp_partial_frame_error),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state
   logic [pbsu_pkg::SBYTES_W-1:0] sb_reg = 3'd2;
   logic [pbsu_pkg::CHANS_W-1:0]  ch_reg = 2'd2;
   logic                          be_reg = 1'b0;
   logic                          lk_reg = 1'b0;
   logic [pbsu_pkg::LENGTH_W-1:0] remain = '0;
   logic [pbsu_pkg::BYTE_W-1:0]   held [HOLD_DEPTH];
   logic [3:0]                    held_cnt = '0;

   pbsu_pkg::rsp_type             frames_expected [$];
   logic [pbsu_pkg::BYTE_W-1:0]   byte_q [$];

   int  bytes_pushed    = 0;
   int  words_checked   = 0;
   int  mismatches      = 0;
   int  frames_seen     = 0;
   int  ends_seen       = 0;
   int  overruns_seen   = 0;
   int  partials_seen   = 0;
   int  phases_run      = 0;
   int  cycle_count     = 0;
   int  idle_mode       = 1;
   int  gap_left        = 0;
   int  stall_left      = 0;

   function automatic int eff_width(logic [pbsu_pkg::SBYTES_W-1:0] sb);
      int w;
      w = sb;
      if (w < 2) w = 2;
      if (w > 4) w = 4;
      return w;
   endfunction

   function automatic int eff_chans(logic [pbsu_pkg::CHANS_W-1:0] ch);
      int c;
      c = ch;
      if (c < 1) c = 1;
      if (c > 2) c = 2;
      return c;
   endfunction

   function automatic logic [pbsu_pkg::SAMPLE_W-1:0] join_sample(int ch, int w);
      logic [pbsu_pkg::SAMPLE_W-1:0] raw;
      int pos;
      raw = '0;
      for (int b = 0; b < w; b++) begin
         pos = be_reg ? b : (w - 1 - b);
         raw = {raw[pbsu_pkg::SAMPLE_W-9:0], held[ch * w + pos]};
      end
      return raw << (pbsu_pkg::SAMPLE_W - 8 * w);
   endfunction

   task automatic unpack_predict(input logic [pbsu_pkg::BYTE_W-1:0] b_in);
      pbsu_pkg::rsp_type r;
      int      w;
      int      c;
      logic    done;
      r = '0;
      w = eff_width(sb_reg);
      c = eff_chans(ch_reg);
      if (lk_reg && remain == 0) begin
         r.length_error = 1'b1;
      end else begin
         if (lk_reg) remain = remain - 1'b1;
         if (held_cnt < HOLD_DEPTH) held[held_cnt[2:0]] = b_in;
         held_cnt = held_cnt + 1'b1;
         if (held_cnt >= w * c) begin
            r.frame_valid = 1'b1;
            r.left_sample = join_sample(0, w);
            if (c > 1) r.right_sample = join_sample(1, w);
            held_cnt = '0;
         end
      end
      done = lk_reg && remain == 0;
      r.body_end = done;
      r.partial_frame_error = done && held_cnt != 0;
      frames_expected.push_back(r);
   endtask

   task automatic check_field(string nm, logic [pbsu_pkg::SAMPLE_W-1:0] e,
                              logic [pbsu_pkg::SAMPLE_W-1:0] a);
      if (e !== a) begin
         $display("%0t %s expected %h actual %h", $time, nm, e, a);
         mismatches++;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      unique case (idle_mode)
         0: return 0;
         1: begin
            if (r < 10) return 0;
            if (r < 15) return $urandom_range(1, 3);
            return $urandom_range(8, 40);
         end
         default: begin
            if (r < 5) return 0;
            if (r < 13) return $urandom_range(1, 4);
            return $urandom_range(8, 40);
         end
      endcase
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            req_valid     <= 1'b1;
            req_data_byte <= byte_q.pop_front();
            gap_left      <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin : rsp_stall_gen
      int n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         n = pick_gap();
         rsp_stall  <= n != 0;
         stall_left <= (n != 0) ? n - 1 : 0;
      end
   end

   // monitor: register shadow, prediction, result check
   always @(posedge clock) begin : result_check
      pbsu_pkg::rsp_type e;
      if (reset) begin
         sb_reg   = 3'd2;
         ch_reg   = 2'd2;
         be_reg   = 1'b0;
         lk_reg   = 1'b0;
         remain   = '0;
         held_cnt = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pbsu_pkg::CSR_SAMPLE_BYTES:  sb_reg = csr_data[pbsu_pkg::SBYTES_W-1:0];
               pbsu_pkg::CSR_CHANNEL_COUNT: ch_reg = csr_data[pbsu_pkg::CHANS_W-1:0];
               pbsu_pkg::CSR_BIG_ENDIAN:    be_reg = csr_data[0];
               pbsu_pkg::CSR_LENGTH_KNOWN:  lk_reg = csr_data[0];
               pbsu_pkg::CSR_BODY_LENGTH:   remain = csr_data[pbsu_pkg::LENGTH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) unpack_predict(req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (frames_expected.size() == 0) begin
               $display("%0t unexpected rsp word: expected none, actual %h %h", $time,
                        rsp_left_sample, rsp_right_sample);
               mismatches++;
            end else begin
               e = frames_expected.pop_front();
               check_field("frame_valid", 32'(e.frame_valid), 32'(rsp_frame_valid));
               check_field("left_sample", e.left_sample, rsp_left_sample);
               check_field("right_sample", e.right_sample, rsp_right_sample);
               check_field("body_end", 32'(e.body_end), 32'(rsp_body_end));
               check_field("length_error", 32'(e.length_error), 32'(rsp_length_error));
               check_field("partial_frame_error", 32'(e.partial_frame_error),
                           32'(rsp_partial_frame_error));
            end
            frames_seen   += rsp_frame_valid;
            ends_seen     += rsp_body_end;
            overruns_seen += rsp_length_error;
            partials_seen += rsp_partial_frame_error;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout: %0d words still pending", $time, frames_expected.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [pbsu_pkg::CSR_DATA_W-1:0] junk63();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[pbsu_pkg::CSR_DATA_W-1:0];
   endfunction

   task automatic csr_write(input logic [pbsu_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pbsu_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // upper data bits carry junk that the block must ignore
   task automatic set_format(input int sb, input int ch, input int be, input int lk);
      csr_write(pbsu_pkg::CSR_SAMPLE_BYTES,
                (junk63() << pbsu_pkg::SBYTES_W) | pbsu_pkg::CSR_DATA_W'(sb));
      csr_write(pbsu_pkg::CSR_CHANNEL_COUNT,
                (junk63() << pbsu_pkg::CHANS_W) | pbsu_pkg::CSR_DATA_W'(ch));
      csr_write(pbsu_pkg::CSR_BIG_ENDIAN, (junk63() << 1) | pbsu_pkg::CSR_DATA_W'(be));
      csr_write(pbsu_pkg::CSR_LENGTH_KNOWN, (junk63() << 1) | pbsu_pkg::CSR_DATA_W'(lk));
   endtask

   task automatic push_byte(input logic [pbsu_pkg::BYTE_W-1:0] b_in);
      byte_q.push_back(b_in);
      bytes_pushed++;
   endtask

   // first byte in the top of the word
   task automatic push_seq(input int n, input logic [63:0] bytes);
      for (int i = 0; i < n; i++) push_byte(bytes[63 - 8 * i -: 8]);
   endtask

   function automatic logic [pbsu_pkg::BYTE_W-1:0] rand_sample_byte();
      unique case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic drain();
      while (words_checked != bytes_pushed) @(posedge clock);
      repeat (3) @(posedge clock);
      phases_run++;
   endtask

   initial begin : stimulus
      int sb, ch, f, n, len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, then unused indices
      push_seq(4, 64'h0080_FF7F_0000_0000);
      drain();
      for (int i = pbsu_pkg::CSR_BODY_LENGTH + 1; i < 2 ** pbsu_pkg::CSR_INDEX_W; i++) begin
         csr_write(pbsu_pkg::CSR_INDEX_W'(i), junk63());
      end
      set_format(2, 2, 0, 0);
      csr_write(pbsu_pkg::CSR_BODY_LENGTH, junk63());
      push_seq(4, 64'hFF80_007F_0000_0000);
      drain();
      set_format(4, 2, 1, 0);
      push_seq(8, 64'hFFFF_FFFF_8000_0000);
      drain();
      set_format(3, 1, 0, 0);
      push_seq(3, 64'h0102_8000_0000_0000);
      drain();
      // format shrinks mid-frame
      set_format(4, 2, 1, 0);
      push_seq(5, 64'h8112_3456_7800_0000);
      drain();
      set_format(2, 1, 1, 0);
      push_seq(1, 64'h9900_0000_0000_0000);
      drain();
      // out-of-range widths and channel counts
      set_format(0, 3, 0, 0);
      push_seq(4, 64'h0180_FE7F_0000_0000);
      drain();
      set_format(7, 0, 1, 0);
      push_seq(4, 64'h7FFF_FFFF_0000_0000);
      drain();
      // short body ends on a partial frame, then overruns
      set_format(2, 2, 0, 1);
      csr_write(pbsu_pkg::CSR_BODY_LENGTH, 63'd3);
      push_seq(4, 64'h1122_3344_0000_0000);
      drain();
      csr_write(pbsu_pkg::CSR_BODY_LENGTH, '0);
      push_seq(1, 64'h5500_0000_0000_0000);
      drain();
      csr_write(pbsu_pkg::CSR_BODY_LENGTH, {pbsu_pkg::LENGTH_W{1'b1}});
      push_seq(2, 64'hAA55_0000_0000_0000);
      drain();

      while (bytes_pushed < RANDOM_BYTES + 40) begin
         idle_mode = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
         sb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
         ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
         f = eff_width(pbsu_pkg::SBYTES_W'(sb)) * eff_chans(pbsu_pkg::CHANS_W'(ch));
         if ($urandom_range(0, 3) != 0) begin
            set_format(sb, ch, $urandom_range(0, 1), 1);
            len = f * $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0) len += $urandom_range(1, f - 1);
            n = len;
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
            if ($urandom_range(0, 9) == 0) begin
               csr_write(pbsu_pkg::CSR_BODY_LENGTH, junk63());
            end else begin
               csr_write(pbsu_pkg::CSR_BODY_LENGTH, pbsu_pkg::CSR_DATA_W'(len));
            end
         end else begin
            set_format(sb, ch, $urandom_range(0, 1), 0);
            n = $urandom_range(1, 60);
         end
         for (int i = 0; i < n; i++) push_byte(rand_sample_byte());
         drain();
      end
      idle_mode = 1;
      set_format(2, 2, 0, 0);
      drain();

      $display("Ran %0d bytes in %0d drained phases over %0d cycles.", bytes_pushed,
               phases_run, cycle_count);
      $display("Saw %0d frames, %0d body ends, %0d overrun bytes, %0d partial-frame ends.",
               frames_seen, ends_seen, overruns_seen, partials_seen);
      if (mismatches == 0 && frames_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
